/* design/atl_pkg.sv */
// ----------------------------------------------------------------------------
// atl_pkg
// Shared types, token kind codes and constants of the assembly token lexer.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int MAX_TOKEN_CHARS_DEF = 256;
    localparam int LINE_BITS_DEF       = 20;
    localparam int COLUMN_BITS_DEF     = 16;

    localparam int KIND_W  = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 9;

    localparam logic [KIND_W-1:0] K_LABEL = 5'd19;
    localparam logic [KIND_W-1:0] K_INT   = 5'd20;
    localparam logic [KIND_W-1:0] K_BOOL  = 5'd21;
    localparam logic [KIND_W-1:0] K_NL    = 5'd22;
    localparam logic [KIND_W-1:0] K_IDENT = 5'd23;
    localparam logic [KIND_W-1:0] K_BAD   = 5'd24;
    localparam logic [KIND_W-1:0] K_LONG  = 5'd25;

    localparam int NUM_MNEM = 19;

    // mnemonic text, byte i at bits 8i, zero padded to six bytes
    function automatic logic [47:0] mnem_text(input int idx);
        logic [47:0] t;
        case (idx)
            0:       t = 48'h0000706f6f6e; // noop
            1:       t = 48'h000000706d6a; // jmp
            2:       t = 48'h00007a71656a; // jeqz
            3:       t = 48'h000068737570; // push
            4:       t = 48'h000000646461; // add
            5:       t = 48'h000000627573; // sub
            6:       t = 48'h0000006c756d; // mul
            7:       t = 48'h000000007165; // eq
            8:       t = 48'h00000000746c; // lt
            9:       t = 48'h00000000656c; // le
            10:      t = 48'h000000007467; // gt
            11:      t = 48'h000000006567; // ge
            12:      t = 48'h0000646e616c; // land
            13:      t = 48'h000000726f6c; // lor
            14:      t = 48'h000067656e6c; // lneg
            15:      t = 48'h006863746566; // fetch
            16:      t = 48'h0065726f7473; // store
            17:      t = 48'h63746e697270; // printc
            18:      t = 48'h76746e697270; // printv
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] mnem_len(input int idx);
        logic [3:0] l;
        case (idx)
            0, 2, 3, 12, 14:            l = 4'd4;
            7, 8, 9, 10, 11:            l = 4'd2;
            15, 16:                     l = 4'd5;
            17, 18:                     l = 4'd6;
            default:                    l = 4'd3;
        endcase
        return l;
    endfunction

    // what the front hands to the classifier for one finished slot
    typedef struct packed {
        logic        is_nl;      // newline token
        logic        is_long;    // too-long token
        logic [47:0] prefix;
        logic [31:0] digits;
        logic        not_id;
        logic        not_int;
        logic        neg;
        logic        colon;
        logic [8:0]  len_raw;    // token length, masked
        logic        len_short;  // length below seven, for keyword compare
        logic [2:0]  len_small;
        logic [31:0] line;
        logic [31:0] col;
        logic        last;
    } slot_t;

endpackage

/* design/atl_front.sv */
// ----------------------------------------------------------------------------
// atl_front
// Accepts bytes, tracks line and column, builds tokens and pushes finished
// token slots. A token slot is classified later; the halt decision for a bad
// token is made here from the same flags so the front knows at once.
// ----------------------------------------------------------------------------
module atl_front #(
    parameter int MAX_TOKEN_CHARS = atl_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int LINE_BITS       = atl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS     = atl_pkg::COLUMN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    output logic                push_valid,
    output logic [1:0]          push_count,
    output atl_pkg::slot_t      push_slot0,
    output atl_pkg::slot_t      push_slot1,
    input  logic                queue_room2
);
    import atl_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_TOP  = {COLUMN_BITS{1'b1}};

    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [COLUMN_BITS-1:0] start_reg, start_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic [31:0]            acc_reg, acc_next;
    logic                   notid_reg, notid_next;
    logic                   notint_reg, notint_next;
    logic                   neg_reg, neg_next;
    logic                   colon_reg, colon_next;
    logic                   slash_reg, slash_next;
    logic                   comment_reg, comment_next;
    logic                   halt_reg, halt_next;

    logic                   take;
    slot_t                  s0, s1;
    logic [1:0]             n;
    slot_t                  tok;

    assign in_stall = !queue_room2;
    assign take     = in_valid && !in_stall;

    // keyword and bad test on the current token, used for halt only
    function automatic logic is_bad(input slot_t t);
        logic kw;
        kw = 1'b0;
        for (int i = 0; i < NUM_MNEM; i++)
        begin
            if (t.len_short && {1'b0, t.len_small} == mnem_len(i)
                && t.prefix == mnem_text(i))
            begin
                kw = 1'b1;
            end
        end
        if (t.len_short && t.len_small == 3'd5 && t.prefix == 48'h0065736c6166)
        begin
            kw = 1'b1;
        end
        if (t.len_short && t.len_small == 3'd4 && t.prefix == 48'h000065757274)
        begin
            kw = 1'b1;
        end
        return !(kw || t.colon || !t.not_int || !t.not_id);
    endfunction

    function automatic slot_t mk_nl(input logic [31:0] ln, input logic [31:0] cl);
        slot_t t;
        t = '0;
        t.is_nl = 1'b1;
        t.line  = ln;
        t.col   = cl;
        return t;
    endfunction

    // current token as a slot
    always_comb
    begin
        tok           = '0;
        tok.prefix    = prefix_reg;
        tok.digits    = acc_reg;
        tok.not_id    = notid_reg;
        tok.not_int   = notint_reg;
        tok.neg       = neg_reg;
        tok.colon     = colon_reg;
        tok.len_raw   = LEN_W'(cnt_reg);
        tok.len_short = cnt_reg <= CNT_W'(6);
        tok.len_small = cnt_reg[2:0];
        tok.line      = 32'(line_reg);
        tok.col       = 32'(start_reg);
    end

    // byte step
    always_comb
    begin
        logic [COLUMN_BITS-1:0] c;
        logic [COLUMN_BITS-1:0] cinc;
        logic [COLUMN_BITS-1:0] ccol;
        logic                   line_done;
        logic                   stop;
        logic                   sep;
        logic                   digit;
        logic                   alnum;
        logic [CNT_W-1:0]       cn;

        line_next    = line_reg;
        col_next     = col_reg;
        start_next   = start_reg;
        cnt_next     = cnt_reg;
        prefix_next  = prefix_reg;
        acc_next     = acc_reg;
        notid_next   = notid_reg;
        notint_next  = notint_reg;
        neg_next     = neg_reg;
        colon_next   = colon_reg;
        slash_next   = slash_reg;
        comment_next = comment_reg;
        halt_next    = halt_reg;
        s0 = '0;
        s1 = '0;
        n  = 2'd0;
        line_done = 1'b0;
        stop      = 1'b0;
        c    = col_reg;
        cinc = (c == COL_TOP) ? COL_TOP : c + 1'b1;
        // comment newline column
        if (32'(cnt_reg) >= 32'(c))
        begin
            ccol = COLUMN_BITS'(1);
        end
        else
        begin
            ccol = COLUMN_BITS'(32'(c) - 32'(cnt_reg) + 32'd1);
        end
        sep   = text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0d
                || text_byte == 8'h0a;
        digit = text_byte >= 8'h30 && text_byte <= 8'h39;
        alnum = digit || (text_byte >= 8'h61 && text_byte <= 8'h7a)
                || (text_byte >= 8'h41 && text_byte <= 8'h5a);
        cn = cnt_reg;

        if (take && !halt_reg)
        begin
            col_next = cinc;
            if (comment_reg)
            begin
                if (text_byte == 8'h0a)
                begin
                    s0 = mk_nl(32'(line_reg), 32'(ccol));
                    n = 2'd1;
                    line_done = 1'b1;
                end
            end
            else if (sep)
            begin
                if (cnt_reg != '0)
                begin
                    s0 = tok;
                    n = 2'd1;
                    if (is_bad(tok))
                    begin
                        halt_next = 1'b1;
                        stop = 1'b1;
                    end
                end
                if (!stop)
                begin
                    if (text_byte == 8'h0a)
                    begin
                        if (n == 2'd0) s0 = mk_nl(32'(line_reg), 32'(c));
                        else           s1 = mk_nl(32'(line_reg), 32'(c));
                        n = n + 2'd1;
                        line_done = 1'b1;
                    end
                    cnt_next = '0; prefix_next = '0; acc_next = '0;
                    notid_next = 1'b0; notint_next = 1'b0; neg_next = 1'b0;
                    colon_next = 1'b0; slash_next = 1'b0;
                end
            end
            else if (cnt_reg != '0 && text_byte == 8'h2f && slash_reg)
            begin
                comment_next = 1'b1;
            end
            else
            begin
                if (cnt_reg == '0) start_next = c;
                if (!(alnum || text_byte == 8'h5f)) notid_next = 1'b1;
                if (text_byte == 8'h2d && cnt_reg == '0) neg_next = 1'b1;
                else if (digit) acc_next = acc_reg * 32'd10 + 32'(text_byte - 8'h30);
                else notint_next = 1'b1;
                colon_next = text_byte == 8'h3a;
                slash_next = text_byte == 8'h2f;
                for (int i = 0; i < 6; i++)
                begin
                    if (cnt_reg == CNT_W'(i)) prefix_next[8*i +: 8] = text_byte;
                end
                cn = cnt_reg + 1'b1;
                cnt_next = cn;
                if (32'(cn) >= 32'(MAX_TOKEN_CHARS))
                begin
                    s0 = '0;
                    s0.is_long = 1'b1;
                    s0.len_raw = LEN_W'(cn);
                    s0.line = 32'(line_reg);
                    s0.col  = 32'((cnt_reg == '0) ? c : start_reg);
                    n = 2'd1;
                    halt_next = 1'b1;
                    stop = 1'b1;
                end
            end

            // end of text flush
            if (!stop && !line_done && end_of_text)
            begin
                if (comment_next)
                begin
                    s0 = mk_nl(32'(line_reg), 32'(ccol));
                    n = 2'd1;
                end
                else
                begin
                    if (cnt_next != '0)
                    begin
                        s0 = tok;
                        s0.prefix = prefix_next; s0.digits = acc_next;
                        s0.not_id = notid_next; s0.not_int = notint_next;
                        s0.neg = neg_next; s0.colon = colon_next;
                        s0.len_raw = LEN_W'(cnt_next);
                        s0.len_short = cnt_next <= CNT_W'(6);
                        s0.len_small = cnt_next[2:0];
                        s0.col = 32'(start_next);
                        n = 2'd1;
                        if (is_bad(s0))
                        begin
                            halt_next = 1'b1;
                            stop = 1'b1;
                        end
                    end
                    if (!stop)
                    begin
                        if (n == 2'd0) s0 = mk_nl(32'(line_reg), 32'(cinc));
                        else           s1 = mk_nl(32'(line_reg), 32'(cinc));
                        n = n + 2'd1;
                    end
                end
                if (!stop) line_done = 1'b1;
            end
            if (line_done)
            begin
                line_next = (line_reg == LINE_TOP) ? LINE_TOP : line_reg + 1'b1;
                col_next = COLUMN_BITS'(1);
                comment_next = 1'b0;
                cnt_next = '0; prefix_next = '0; acc_next = '0;
                notid_next = 1'b0; notint_next = 1'b0; neg_next = 1'b0;
                colon_next = 1'b0; slash_next = 1'b0;
            end
            if (n == 2'd1) s0.last = 1'b1;
            if (n == 2'd2) s1.last = 1'b1;
        end
    end

    assign push_valid = take && n != 2'd0;
    assign push_count = n;
    assign push_slot0 = s0;
    assign push_slot1 = s1;

    // token and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= LINE_BITS'(1);
            col_reg     <= COLUMN_BITS'(1);
            start_reg   <= COLUMN_BITS'(1);
            cnt_reg     <= '0;
            prefix_reg  <= '0;
            acc_reg     <= '0;
            notid_reg   <= 1'b0;
            notint_reg  <= 1'b0;
            neg_reg     <= 1'b0;
            colon_reg   <= 1'b0;
            slash_reg   <= 1'b0;
            comment_reg <= 1'b0;
            halt_reg    <= 1'b0;
        end
        else
        begin
            line_reg    <= line_next;
            col_reg     <= col_next;
            start_reg   <= start_next;
            cnt_reg     <= cnt_next;
            prefix_reg  <= prefix_next;
            acc_reg     <= acc_next;
            notid_reg   <= notid_next;
            notint_reg  <= notint_next;
            neg_reg     <= neg_next;
            colon_reg   <= colon_next;
            slash_reg   <= slash_next;
            comment_reg <= comment_next;
            halt_reg    <= halt_next;
        end
    end

    // once halted the front stays halted
    assert property (@(posedge clk) disable iff (!rst_n) halt_reg |=> halt_reg)
        else $error("halt cleared without reset");
    // nothing pushed while halted
    assert property (@(posedge clk) disable iff (!rst_n) halt_reg |-> !push_valid)
        else $error("push while halted");
    // token count stays below the limit while running
    assert property (@(posedge clk) disable iff (!rst_n)
        !halt_reg |-> 32'(cnt_reg) < 32'(MAX_TOKEN_CHARS))
        else $error("token count overflow");
endmodule

/* design/atl_back.sv */
// ----------------------------------------------------------------------------
// atl_back
// Four-entry slot queue followed by the classifier and output register.
// ----------------------------------------------------------------------------
module atl_back #(
    parameter int LINE_BITS   = atl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = atl_pkg::COLUMN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push_valid,
    input  logic [1:0]                  push_count,
    input  atl_pkg::slot_t              push_slot0,
    input  atl_pkg::slot_t              push_slot1,
    output logic                        queue_room2,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [atl_pkg::KIND_W-1:0]  tok_class,
    output logic signed [31:0]          token_value,
    output logic                        wide_warning,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [COLUMN_BITS-1:0]      column,
    output logic [atl_pkg::LEN_W-1:0]   token_length,
    output logic                        last_of_run
);
    import atl_pkg::*;

    slot_t      q_reg [4];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] fill_reg, fill_next;
    logic       ov_reg, ov_next;
    logic       pop;
    logic [1:0] pushed;
    slot_t      h;
    logic [KIND_W-1:0] k;
    logic [31:0] v;
    logic        w;

    assign queue_room2 = fill_reg <= 3'd2;
    assign pushed      = push_valid ? push_count : 2'd0;
    assign pop         = fill_reg != 3'd0 && (!ov_reg || !out_stall);
    assign h           = q_reg[rd_reg];

    // classify head slot
    always_comb
    begin
        logic kw;
        k  = K_BAD;
        v  = '0;
        w  = 1'b0;
        kw = 1'b0;
        for (int i = NUM_MNEM - 1; i >= 0; i--)
        begin
            if (h.len_short && {1'b0, h.len_small} == mnem_len(i)
                && h.prefix == mnem_text(i))
            begin
                k  = KIND_W'(i);
                kw = 1'b1;
            end
        end
        if (h.is_nl)
        begin
            k = K_NL;
        end
        else if (h.is_long)
        begin
            k = K_LONG;
        end
        else if (!kw)
        begin
            if (h.colon)
            begin
                k = K_LABEL;
            end
            else if (!h.not_int)
            begin
                k = K_INT;
                v = h.neg ? 32'd0 - h.digits : h.digits;
                w = (v + 32'h0080_0000) >= 32'h0100_0000;
            end
            else if (h.len_short && h.len_small == 3'd5 && h.prefix == 48'h0065736c6166)
            begin
                k = K_BOOL;
            end
            else if (h.len_short && h.len_small == 3'd4 && h.prefix == 48'h000065757274)
            begin
                k = K_BOOL;
                v = 32'd1;
            end
            else if (!h.not_id)
            begin
                k = K_IDENT;
            end
        end
    end

    // queue pointers
    always_comb
    begin
        rd_next   = pop ? rd_reg + 2'd1 : rd_reg;
        wr_next   = wr_reg + pushed;
        fill_next = fill_reg + 3'(pushed) - 3'(pop);
        ov_next   = pop ? 1'b1 : (out_stall ? ov_reg : 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (pushed != 2'd0) q_reg[wr_reg] <= push_slot0;
        if (pushed == 2'd2) q_reg[wr_reg + 2'd1] <= push_slot1;
        if (pop)
        begin
            tok_class    <= k;
            token_value  <= v;
            wide_warning <= w;
            line_number  <= LINE_BITS'(h.line);
            column       <= COLUMN_BITS'(h.col);
            token_length <= h.is_nl ? '0 : h.len_raw;
            last_of_run  <= h.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            fill_reg <= fill_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 3'd4)
        else $error("queue overflow");
    // a push only arrives when two places are free
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> fill_reg <= 3'd2)
        else $error("push into full queue");
    // a held result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tok_class))
        else $error("result lost under stall");
endmodule

/* design/assembly_token_lexer_unit.sv */
// ----------------------------------------------------------------------------
// assembly_token_lexer_unit
// Byte-stream lexer for a small stack-machine assembly language.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while in_stall is low; results pass
// through a four-entry queue and leave from a register. A byte that gives
// two results (token then newline) pushes both into the queue at once; the
// input stalls only when fewer than two queue places are free, set by the
// output side taking one result per cycle while out_stall is low. After a
// bad or too-long token the block drops all bytes until reset.
module assembly_token_lexer_unit #(
    parameter int MAX_TOKEN_CHARS = atl_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int LINE_BITS       = atl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS     = atl_pkg::COLUMN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  text_byte,
    input  logic                        end_of_text,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [atl_pkg::KIND_W-1:0]  tok_class,
    output logic signed [31:0]          token_value,
    output logic                        wide_warning,
    output logic [LINE_BITS-1:0]        line_number,
    output logic [COLUMN_BITS-1:0]      column,
    output logic [atl_pkg::LEN_W-1:0]   token_length,
    output logic                        last_of_run
);
    import atl_pkg::*;

    logic       push_valid;
    logic [1:0] push_count;
    slot_t      push_slot0;
    slot_t      push_slot1;
    logic       queue_room2;

    // front: byte intake and token building
    atl_front #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
        .LINE_BITS(LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .text_byte(text_byte), .end_of_text(end_of_text),
        .push_valid(push_valid), .push_count(push_count),
        .push_slot0(push_slot0), .push_slot1(push_slot1),
        .queue_room2(queue_room2)
    );

    // back: queue, classifier, output register
    atl_back #(
        .LINE_BITS(LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_count(push_count),
        .push_slot0(push_slot0), .push_slot1(push_slot1),
        .queue_room2(queue_room2),
        .out_valid(out_valid), .out_stall(out_stall),
        .tok_class(tok_class), .token_value(token_value),
        .wide_warning(wide_warning), .line_number(line_number),
        .column(column), .token_length(token_length),
        .last_of_run(last_of_run)
    );
endmodule
